>>> design/ofc_pkg.sv
package ofc_pkg;

    // Width of the filter state held in each section.
    localparam int STATE_BITS = 32;

    // Width of the difference fed to the multiplier (y + x - x_prev needs two extra bits).
    localparam int DIFF_BITS = STATE_BITS + 2;

    // Filter modes.
    localparam logic [1:0] MODE_BYPASS   = 2'd0;
    localparam logic [1:0] MODE_LOWPASS  = 2'd1;
    localparam logic [1:0] MODE_HIGHPASS = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] REG_FILTER_MODE = 2'd0;
    localparam logic [1:0] REG_STAGE_COUNT = 2'd1;
    localparam logic [1:0] REG_COEFFICIENT = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIFF,
        ST_MUL,
        ST_UPD,
        ST_DONE
    } ofc_state_t;

endpackage

>>> design/one_pole_filter_cascade.sv
// A request is accepted only in the idle state, and the next one is not taken until its
// result has been loaded into the output register: bypass goes straight to the output slot,
// and filtering runs one or two sections, each in three passes (difference, multiply, update)
// through the one shared subtract/multiply/round unit.
// Reset (rst_n low, asynchronous): filter state cleared to zero, mode bypass, two sections,
// coefficient one half, no result pending.
module one_pole_filter_cascade
    import ofc_pkg::*;
#(
    parameter int SAMPLE_BITS = 24,
    parameter int COEF_BITS   = 16
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Configuration write port.
    input  logic                                 cfg_we,
    input  logic [1:0]                           cfg_index,
    input  logic [COEF_BITS-1:0]                 cfg_data,
    // Input stream.
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]     s_tdata,   // [SAMPLE_BITS-1:0] sample_in
    input  logic [0:0]                           s_tuser,   // [0] first_of_note
    // Output stream.
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]     m_tdata    // [SAMPLE_BITS-1:0] sample_out
);

    localparam int TDATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int PROD_BITS  = DIFF_BITS + COEF_BITS + 1;
    localparam int UPD_BITS   = DIFF_BITS + 3;

    // Saturation limits: the state limits at the width of the update adder, the sample limits at the state width.
    localparam logic signed [UPD_BITS-1:0] STATE_MAX =
        {{(UPD_BITS - STATE_BITS + 1){1'b0}}, {(STATE_BITS - 1){1'b1}}};
    localparam logic signed [UPD_BITS-1:0] STATE_MIN = ~STATE_MAX;
    localparam logic signed [STATE_BITS-1:0] SAMPLE_MAX =
        {{(STATE_BITS - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
    localparam logic signed [STATE_BITS-1:0] SAMPLE_MIN = ~SAMPLE_MAX;

    // Rounding offset: one half of the coefficient scale.
    localparam logic signed [PROD_BITS:0] ROUND_HALF =
        (PROD_BITS + 1)'(1) << (COEF_BITS - 1);

    // Configuration registers.
    logic [1:0]                    mode_reg;
    logic [1:0]                    count_reg;
    logic [COEF_BITS-1:0]          coef_reg;

    // Sequencer.
    ofc_state_t                    state_reg;
    ofc_state_t                    state_next;
    logic                          sec_reg;      // section being worked: 0 first, 1 second
    logic                          seed_reg;

    // Datapath registers of the shared unit.
    logic signed [SAMPLE_BITS-1:0] x_reg;        // section input, later the result
    logic signed [STATE_BITS-1:0]  ybase_reg;    // y after the reseed rule
    logic signed [DIFF_BITS-1:0]   diff_reg;
    logic signed [PROD_BITS-1:0]   prod_reg;

    // Filter state.
    logic signed [STATE_BITS-1:0]  y1_reg;
    logic signed [STATE_BITS-1:0]  y2_reg;
    logic signed [SAMPLE_BITS-1:0] p1_reg;
    logic signed [SAMPLE_BITS-1:0] p2_reg;

    // Output register.
    logic                          out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] out_data_reg;

    // Combinational signals.
    logic                          in_accept;
    logic                          lowpass;
    logic                          filtering;
    logic                          more_sections;
    logic                          out_load;
    logic signed [STATE_BITS-1:0]  y_cur;
    logic signed [SAMPLE_BITS-1:0] p_cur;
    logic signed [STATE_BITS-1:0]  y_eff;
    logic signed [SAMPLE_BITS-1:0] p_eff;
    logic signed [DIFF_BITS-1:0]   diff_val;
    logic signed [PROD_BITS:0]     rnd_full;
    logic signed [UPD_BITS-1:0]    rnd_val;
    logic signed [UPD_BITS-1:0]    upd_sum;
    logic signed [STATE_BITS-1:0]  y_new;
    logic signed [SAMPLE_BITS-1:0] sec_out;

    assign in_accept     = s_tvalid && s_tready;
    assign lowpass       = (mode_reg == MODE_LOWPASS);
    assign filtering     = (mode_reg == MODE_LOWPASS) || (mode_reg == MODE_HIGHPASS);
    assign more_sections = (sec_reg == 1'b0) && count_reg[1];
    assign out_load      = (state_reg == ST_DONE) && (!out_valid_reg || m_tready);

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = TDATA_BITS'(unsigned'(out_data_reg));

    // Configuration writes; index three is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_BYPASS;
            count_reg <= 2'd2;
            coef_reg  <= COEF_BITS'(1) << (COEF_BITS - 1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FILTER_MODE: mode_reg  <= cfg_data[1:0];
                REG_STAGE_COUNT: count_reg <= cfg_data[1:0];
                REG_COEFFICIENT: coef_reg  <= cfg_data;
                default:         ;
            endcase
        end
    end

    // Difference step. A reseed sets y to the input for lowpass and to zero for
    // highpass, and sets the previous input to the current one.
    always_comb
    begin
        y_cur = sec_reg ? y2_reg : y1_reg;
        p_cur = sec_reg ? p2_reg : p1_reg;
        if (seed_reg)
        begin
            y_eff = lowpass ? STATE_BITS'(x_reg) : '0;
            p_eff = x_reg;
        end
        else
        begin
            y_eff = y_cur;
            p_eff = p_cur;
        end
        if (lowpass)
        begin
            diff_val = DIFF_BITS'(x_reg) - DIFF_BITS'(y_eff);
        end
        else
        begin
            diff_val = DIFF_BITS'(y_eff) + DIFF_BITS'(x_reg) - DIFF_BITS'(p_eff);
        end
    end

    // Update step: round to nearest with ties upward, accumulate for lowpass,
    // saturate the state to 32 bits and the passed-on value to the sample width.
    always_comb
    begin
        rnd_full = ((PROD_BITS + 1)'(prod_reg) + ROUND_HALF) >>> COEF_BITS;
        rnd_val  = rnd_full[UPD_BITS-1:0];
        upd_sum  = lowpass ? (rnd_val + UPD_BITS'(ybase_reg)) : rnd_val;
        if (upd_sum > STATE_MAX)
        begin
            y_new = STATE_MAX[STATE_BITS-1:0];
        end
        else if (upd_sum < STATE_MIN)
        begin
            y_new = STATE_MIN[STATE_BITS-1:0];
        end
        else
        begin
            y_new = upd_sum[STATE_BITS-1:0];
        end
        if (y_new > SAMPLE_MAX)
        begin
            sec_out = SAMPLE_MAX[SAMPLE_BITS-1:0];
        end
        else if (y_new < SAMPLE_MIN)
        begin
            sec_out = SAMPLE_MIN[SAMPLE_BITS-1:0];
        end
        else
        begin
            sec_out = y_new[SAMPLE_BITS-1:0];
        end
    end

    // Sequencer state register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state: bypass goes straight to the output slot, filtering runs three
    // passes per section and loops back for the second section.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = filtering ? ST_DIFF : ST_DONE;
                end
            end
            ST_DIFF: state_next = ST_MUL;
            ST_MUL:  state_next = ST_UPD;
            ST_UPD:  state_next = more_sections ? ST_DIFF : ST_DONE;
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Shared datapath and section bookkeeping.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    x_reg    <= s_tdata[SAMPLE_BITS-1:0];
                    seed_reg <= s_tuser[0];
                    sec_reg  <= 1'b0;
                end
            end
            ST_DIFF:
            begin
                diff_reg  <= diff_val;
                ybase_reg <= y_eff;
            end
            ST_MUL:
            begin
                prod_reg <= $signed({1'b0, coef_reg}) * diff_reg;
            end
            ST_UPD:
            begin
                x_reg   <= sec_out;
                sec_reg <= 1'b1;
            end
            ST_DONE: ;
            default: ;
        endcase
    end

    // Filter state; only the section being updated changes. Lowpass leaves the
    // previous input alone.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            y1_reg <= '0;
            y2_reg <= '0;
            p1_reg <= '0;
            p2_reg <= '0;
        end
        else if (state_reg == ST_UPD)
        begin
            if (sec_reg)
            begin
                y2_reg <= y_new;
                if (!lowpass)
                begin
                    p2_reg <= x_reg;
                end
            end
            else
            begin
                y1_reg <= y_new;
                if (!lowpass)
                begin
                    p1_reg <= x_reg;
                end
            end
        end
    end

    // Output register: holds a result until the downstream side takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= x_reg;
        end
    end

endmodule

>>> design/ofc_checker.sv
module ofc_checker
#(
    parameter int SAMPLE_BITS = 24,
    parameter int COEF_BITS   = 16
)
(
    input logic                             clk,
    input logic                             rst_n,
    input logic                             cfg_we,
    input logic [1:0]                       cfg_index,
    input logic [COEF_BITS-1:0]             cfg_data,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic [((SAMPLE_BITS+7)/8)*8-1:0] s_tdata,
    input logic [0:0]                       s_tuser,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [((SAMPLE_BITS+7)/8)*8-1:0] m_tdata
);

    // A result that is not taken stays put.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output result dropped or changed while stalled");

    // The block works on one request at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while the previous one is still in work");

    // A result never appears in the cycle right after its request.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
        else $error("result appeared too early");

    // No result is pending during reset.
    assert property (@(posedge clk) !rst_n |-> !m_tvalid)
        else $error("output valid during reset");

    // The padding bits above the sample stay zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata >> SAMPLE_BITS) == '0)
        else $error("output padding bits not zero");

endmodule

bind one_pole_filter_cascade ofc_checker #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COEF_BITS   (COEF_BITS)
) u_ofc_checker (.*);

>>> test/filter_checker.sv
`timescale 1ns / 1ps

// Watches the configuration port and both streams of the filter cascade. It keeps its own
// copy of the registers and the section state, works out the filtered sample for every
// accepted request and compares it with the results in order.
module filter_checker
    import ofc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,    // [23:0] sample_in
    input  logic [0:0]  s_tuser,    // [0] first_of_note
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,    // [23:0] sample_out
    output int          outstanding,
    output int          mismatches
);

    localparam int SAMPLE_BITS = 24;
    localparam int COEF_BITS   = 16;
    localparam int REPORT_MAX  = 10;

    logic [1:0]             mode;
    logic [1:0]             stages;
    logic [COEF_BITS-1:0]   coef;
    longint                 y_state [2];
    longint                 prev_state [2];
    logic [SAMPLE_BITS-1:0] expected_samples [$];
    int                     error_count = 0;

    function automatic longint saturate(longint value, int bits);
        longint hi;
        longint lo;
        hi = (longint'(1) << (bits - 1)) - 1;
        lo = -hi - 1;
        if (value > hi)
            return hi;
        if (value < lo)
            return lo;
        return value;
    endfunction

    // alpha * d, rounded to nearest with ties toward plus infinity.
    function automatic longint scale_by_coef(longint d);
        longint product;
        product = longint'(coef) * d + (longint'(1) << (COEF_BITS - 1));
        return product >>> COEF_BITS;
    endfunction

    function automatic longint run_section(int idx, longint x, bit reseed);
        if (mode == MODE_LOWPASS)
        begin
            if (reseed)
                y_state[idx] = x;
            y_state[idx] = saturate(y_state[idx] + scale_by_coef(x - y_state[idx]),
                                    STATE_BITS);
        end
        else
        begin
            if (reseed)
            begin
                y_state[idx]    = 0;
                prev_state[idx] = x;
            end
            y_state[idx] = saturate(scale_by_coef(y_state[idx] + x - prev_state[idx]),
                                    STATE_BITS);
            prev_state[idx] = x;
        end
        return saturate(y_state[idx], SAMPLE_BITS);
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] predict_filtered(logic signed [23:0] sample,
                                                                bit reseed);
        longint y;
        y = sample;
        if (mode == MODE_LOWPASS || mode == MODE_HIGHPASS)
        begin
            y = run_section(0, y, reseed);
            if (stages >= 2'd2)
                y = run_section(1, y, reseed);
        end
        return y[SAMPLE_BITS-1:0];
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            mode       = MODE_BYPASS;
            stages     = 2'd2;
            coef       = 16'd32768;
            y_state    = '{0, 0};
            prev_state = '{0, 0};
            expected_samples.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_FILTER_MODE: mode   = cfg_data[1:0];
                    REG_STAGE_COUNT: stages = cfg_data[1:0];
                    REG_COEFFICIENT: coef   = cfg_data;
                    default: ;
                endcase
            end

            if (m_tvalid && m_tready)
            begin
                if (expected_samples.size() == 0)
                begin
                    error_count++;
                    if (error_count <= REPORT_MAX)
                        $display("%0t: unexpected result sample_out=%h", $realtime, m_tdata);
                end
                else
                begin
                    if (m_tdata !== expected_samples[0])
                    begin
                        error_count++;
                        if (error_count <= REPORT_MAX)
                            $display("%0t: sample_out mismatch, expected %h, got %h",
                                     $realtime, expected_samples[0], m_tdata);
                    end
                    void'(expected_samples.pop_front());
                end
            end

            if (s_tvalid && s_tready)
                expected_samples.insert(expected_samples.size(),
                                        predict_filtered(s_tdata, s_tuser[0]));
        end
        outstanding <= expected_samples.size();
        mismatches  <= error_count;
    end

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps

// Drives the filter cascade with samples in phases of fixed register settings and gives the
// verdict. The checker beside the block does all prediction and comparison.
module testbench;

    import ofc_pkg::*;

    // Mode 3 is not defined and must act as bypass; index 3 names no register and must be
    // ignored by the block.
    localparam logic [1:0] MODE_UNDEFINED = 2'd3;
    localparam logic [1:0] REG_UNUSED     = 2'd3;

    localparam int RANDOM_ITEMS = 1400;
    // Extra wait after the last result before the block counts as idle.
    localparam int SETTLE_CYCLES = 16;
    // The limit is set above the slowest correct run, pauses between phases included.
    localparam int CYCLE_LIMIT = 300000;

    localparam logic signed [23:0] SAMPLE_MAX = 24'sh7FFFFF;
    localparam logic signed [23:0] SAMPLE_MIN = 24'sh800000;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // [23:0] sample_in
    logic [0:0]  s_tuser;   // [0] first_of_note
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // [23:0] sample_out

    int          outstanding;
    int          mismatches;
    int unsigned max_gap = 7;
    int unsigned cycle_count = 0;

    one_pole_filter_cascade dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    filter_checker u_filter_checker
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .outstanding (outstanding),
        .mismatches  (mismatches)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // The run is cut off if it has not ended by the limit.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL one_pole_filter_cascade");
        $finish;
    end

    // Result side: before every result the receiver holds off for a random number of cycles.
    // max_gap drops to zero in some phases, which gives stretches of full-rate traffic.
    initial
    begin
        int unsigned stall;
        m_tready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            stall = $urandom_range(0, max_gap);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
        end
    end

    // Sends one sample request after a random gap. The valid is left high on return, so a
    // request that follows without a gap goes out on the next cycle.
    task automatic send_sample(input logic signed [23:0] sample, input logic first_flag);
        int unsigned gap;
        gap = $urandom_range(0, max_gap);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid   <= 1'b1;
        s_tdata    <= sample;
        s_tuser[0] <= first_flag;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // Stops sending and waits until every predicted sample has come out. The first edge is
    // skipped because the checker's count is registered.
    task automatic drain;
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes all three registers and then the unused index. The mode and stage count are
    // written with junk in the upper data bits, which the block must drop.
    task automatic write_settings(input logic [1:0] mode, input logic [1:0] stages,
                                  input logic [15:0] coef);
        cfg_we    <= 1'b1;
        cfg_index <= REG_FILTER_MODE;
        cfg_data  <= {14'($urandom), mode};
        @(posedge clk);
        cfg_index <= REG_STAGE_COUNT;
        cfg_data  <= {14'($urandom), stages};
        @(posedge clk);
        cfg_index <= REG_COEFFICIENT;
        cfg_data  <= coef;
        @(posedge clk);
        cfg_index <= REG_UNUSED;
        cfg_data  <= 16'($urandom);
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Mostly full-range samples, with the extremes and values near zero mixed in.
    function automatic logic signed [23:0] random_sample();
        case ($urandom_range(0, 9))
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            2:       return 24'($signed($urandom_range(0, 512)) - 256);
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic logic [1:0] random_mode();
        case ($urandom_range(0, 9))
            0:       return MODE_BYPASS;
            1:       return MODE_UNDEFINED;
            2, 3, 4,
            5:       return MODE_LOWPASS;
            default: return MODE_HIGHPASS;
        endcase
    endfunction

    initial
    begin
        int unsigned items_sent;
        int unsigned phase_len;
        logic [15:0] coef;

        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= REG_FILTER_MODE;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: bypass, so the extremes must pass through unchanged.
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(SAMPLE_MIN, 1'b1);
        drain();

        // The undefined mode must act as bypass as well; a stage count of zero is set too.
        write_settings(MODE_UNDEFINED, 2'd0, 16'd0);
        send_sample(SAMPLE_MAX, 1'b1);
        send_sample(-24'sd1, 1'b0);
        drain();

        // Single lowpass section with the largest alpha. The first sample reseeds, so its
        // output equals its input.
        write_settings(MODE_LOWPASS, 2'd1, 16'hFFFF);
        send_sample(SAMPLE_MIN, 1'b1);
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(24'sd0, 1'b0);
        send_sample(SAMPLE_MAX, 1'b0);
        drain();

        // Stage count 3 acts as two sections. Alpha zero holds the lowpass state still, and
        // the first sample reseeds both sections.
        write_settings(MODE_LOWPASS, 2'd3, 16'd0);
        send_sample(SAMPLE_MAX, 1'b1);
        send_sample(SAMPLE_MIN, 1'b0);
        drain();

        // Two highpass sections driven by full-scale steps, so the outputs overshoot and
        // saturate. The reseeded first sample gives zero.
        write_settings(MODE_HIGHPASS, 2'd2, 16'hFFFF);
        send_sample(SAMPLE_MIN, 1'b1);
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(SAMPLE_MIN, 1'b0);
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(SAMPLE_MIN, 1'b0);
        drain();

        // Changing settings without a reseed: the highpass and then the lowpass pick up the shared state.
        write_settings(MODE_HIGHPASS, 2'd1, 16'd40000);
        send_sample(24'sd0, 1'b0);
        send_sample(SAMPLE_MAX, 1'b0);
        drain();

        write_settings(MODE_LOWPASS, 2'd2, 16'd1);
        send_sample(SAMPLE_MIN, 1'b0);
        send_sample(SAMPLE_MAX, 1'b0);
        drain();

        // Random phases. Each phase runs one setting of the registers and usually opens a
        // new note; a few notes also start in the middle of a phase.
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 7))
                0:       coef = 16'd0;
                1:       coef = 16'hFFFF;
                default: coef = 16'($urandom);
            endcase
            write_settings(random_mode(), 2'($urandom), coef);
            max_gap   = ($urandom_range(0, 3) == 0) ? 0 : 7;
            phase_len = $urandom_range(20, 80);
            for (int unsigned i = 0; i < phase_len; i++)
            begin
                if (i == 0)
                    send_sample(random_sample(), $urandom_range(0, 3) != 0);
                else
                    send_sample(random_sample(), $urandom_range(0, 19) == 0);
            end
            items_sent += phase_len;
            drain();
        end

        if (mismatches == 0 && outstanding == 0)
            $display("PASS one_pole_filter_cascade");
        else
            $display("FAIL one_pole_filter_cascade");
        $finish;
    end

endmodule

>>> filelist.f
design/ofc_pkg.sv
design/one_pole_filter_cascade.sv
design/ofc_checker.sv
test/filter_checker.sv
test/testbench.sv
